// ===== src/qrp_pkg.sv =====
package qrp_pkg;

    // Field and register formats
    localparam int COORD_WIDTH    = 24;
    localparam int QUAT_FRAC_BITS = 14;
    localparam int QREG_WIDTH     = 16;
    localparam int CFG_INDEX_W    = 8;
    localparam int REG_COUNT      = 4;

    // Register positions in the quaternion store
    localparam int QPOS_W = 0;
    localparam int QPOS_X = 1;
    localparam int QPOS_Y = 2;
    localparam int QPOS_Z = 3;

    // Register addresses on the configuration port
    localparam logic [CFG_INDEX_W-1:0] ADDR_QUAT_W = CFG_INDEX_W'(QPOS_W);
    localparam logic [CFG_INDEX_W-1:0] ADDR_QUAT_X = CFG_INDEX_W'(QPOS_X);
    localparam logic [CFG_INDEX_W-1:0] ADDR_QUAT_Y = CFG_INDEX_W'(QPOS_Y);
    localparam logic [CFG_INDEX_W-1:0] ADDR_QUAT_Z = CFG_INDEX_W'(QPOS_Z);

    // Doubled component products 2*a*b
    localparam int PROD_QQ_W = 2 * QREG_WIDTH + 1;

    // Matrix entries carry 2*QUAT_FRAC_BITS fraction bits
    localparam int ENTRY_W = (2 * QREG_WIDTH + 2 > 2 * QUAT_FRAC_BITS + 2) ?
                             2 * QREG_WIDTH + 2 : 2 * QUAT_FRAC_BITS + 2;
    localparam int LO_W    = ENTRY_W / 2;
    localparam int HI_W    = ENTRY_W - LO_W;

    // Partial products, merged products, row sums
    localparam int LO_PP_W   = LO_W + 1 + COORD_WIDTH;
    localparam int HI_PP_W   = HI_W + COORD_WIDTH;
    localparam int PROD_W    = ENTRY_W + COORD_WIDTH;
    localparam int SUM_W     = PROD_W + 2;
    localparam int RND_SHIFT = 2 * QUAT_FRAC_BITS;
    localparam int RND_W     = SUM_W - RND_SHIFT;

    typedef logic signed [QREG_WIDTH-1:0]  quat_t;
    typedef logic signed [ENTRY_W-1:0]     entry_t;
    typedef entry_t [8:0]                  matrix_t;
    typedef logic signed [COORD_WIDTH-1:0] coord_t;

    localparam quat_t  QUAT_ONE = QREG_WIDTH'(1) << QUAT_FRAC_BITS;
    localparam entry_t MAT_ONE  = ENTRY_W'(1) << RND_SHIFT;

    localparam logic signed [SUM_W-1:0] RND_HALF = SUM_W'(1) << (RND_SHIFT - 1);

    localparam coord_t COORD_MAX = {1'b0, {(COORD_WIDTH - 1){1'b1}}};
    localparam coord_t COORD_MIN = {1'b1, {(COORD_WIDTH - 1){1'b0}}};

    typedef struct packed {
        logic [REG_COUNT-1:0] sel;
        quat_t                data;
    } cfg_wr_t;

endpackage

// ===== src/qrp_point_if.sv =====
interface qrp_point_if;
    import qrp_pkg::*;

    logic   valid;
    logic   ready;
    coord_t point_x;
    coord_t point_y;
    coord_t point_z;

    modport source (output valid, output point_x, output point_y, output point_z,
                    input ready);
    modport sink   (input valid, input point_x, input point_y, input point_z,
                    output ready);
endinterface

// ===== src/qrp_rotated_if.sv =====
interface qrp_rotated_if;
    import qrp_pkg::*;

    logic   valid;
    logic   ready;
    coord_t rotated_x;
    coord_t rotated_y;
    coord_t rotated_z;

    modport source (output valid, output rotated_x, output rotated_y, output rotated_z,
                    input ready);
    modport sink   (input valid, input rotated_x, input rotated_y, input rotated_z,
                    output ready);
endinterface

// ===== src/qrp_matrix.sv =====
module qrp_matrix (
    input  logic             clk,
    input  logic             rst_n,
    input  qrp_pkg::cfg_wr_t cfg,
    output qrp_pkg::matrix_t mat
);
    import qrp_pkg::*;

    localparam int P_XX       = 0;
    localparam int P_YY       = 1;
    localparam int P_ZZ       = 2;
    localparam int P_XY       = 3;
    localparam int P_XZ       = 4;
    localparam int P_YZ       = 5;
    localparam int P_WX       = 6;
    localparam int P_WY       = 7;
    localparam int P_WZ       = 8;
    localparam int PROD_COUNT = 9;
    localparam int CHK_W      = ENTRY_W + 3;

    localparam matrix_t MAT_RESET = {MAT_ONE, {3{entry_t'(0)}}, MAT_ONE,
                                     {3{entry_t'(0)}}, MAT_ONE};

    quat_t                       q_reg     [REG_COUNT];
    quat_t                       q_next    [REG_COUNT];
    logic signed [PROD_QQ_W-1:0] prod_reg  [PROD_COUNT];
    logic signed [PROD_QQ_W-1:0] prod_next [PROD_COUNT];
    matrix_t                     mat_reg;
    matrix_t                     mat_next;

    function automatic logic signed [PROD_QQ_W-1:0] dbl_mul(quat_t a, quat_t b);
        logic signed [2*QREG_WIDTH-1:0] p;
        p = a * b;
        return {p, 1'b0};
    endfunction

    function automatic entry_t ext(logic signed [PROD_QQ_W-1:0] v);
        return ENTRY_W'(v);
    endfunction

    always_comb
    begin
        for (int i = 0; i < REG_COUNT; i++)
        begin
            q_next[i] = cfg.sel[i] ? cfg.data : q_reg[i];
        end
    end

    // Products come from the incoming register values, so they are registered
    // together with the write itself and the matrix register follows from them.
    always_comb
    begin
        prod_next[P_XX] = dbl_mul(q_next[QPOS_X], q_next[QPOS_X]);
        prod_next[P_YY] = dbl_mul(q_next[QPOS_Y], q_next[QPOS_Y]);
        prod_next[P_ZZ] = dbl_mul(q_next[QPOS_Z], q_next[QPOS_Z]);
        prod_next[P_XY] = dbl_mul(q_next[QPOS_X], q_next[QPOS_Y]);
        prod_next[P_XZ] = dbl_mul(q_next[QPOS_X], q_next[QPOS_Z]);
        prod_next[P_YZ] = dbl_mul(q_next[QPOS_Y], q_next[QPOS_Z]);
        prod_next[P_WX] = dbl_mul(q_next[QPOS_W], q_next[QPOS_X]);
        prod_next[P_WY] = dbl_mul(q_next[QPOS_W], q_next[QPOS_Y]);
        prod_next[P_WZ] = dbl_mul(q_next[QPOS_W], q_next[QPOS_Z]);
    end

    always_comb
    begin
        mat_next[0] = MAT_ONE - (ext(prod_reg[P_YY]) + ext(prod_reg[P_ZZ]));
        mat_next[1] = ext(prod_reg[P_XY]) - ext(prod_reg[P_WZ]);
        mat_next[2] = ext(prod_reg[P_XZ]) + ext(prod_reg[P_WY]);
        mat_next[3] = ext(prod_reg[P_XY]) + ext(prod_reg[P_WZ]);
        mat_next[4] = MAT_ONE - (ext(prod_reg[P_XX]) + ext(prod_reg[P_ZZ]));
        mat_next[5] = ext(prod_reg[P_YZ]) - ext(prod_reg[P_WX]);
        mat_next[6] = ext(prod_reg[P_XZ]) - ext(prod_reg[P_WY]);
        mat_next[7] = ext(prod_reg[P_YZ]) + ext(prod_reg[P_WX]);
        mat_next[8] = MAT_ONE - (ext(prod_reg[P_XX]) + ext(prod_reg[P_YY]));
    end

    // Reset quaternion is identity: every doubled product is zero and the
    // matrix is the unit matrix.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg[QPOS_W] <= QUAT_ONE;
            q_reg[QPOS_X] <= '0;
            q_reg[QPOS_Y] <= '0;
            q_reg[QPOS_Z] <= '0;
            for (int i = 0; i < PROD_COUNT; i++)
            begin
                prod_reg[i] <= '0;
            end
            mat_reg <= MAT_RESET;
        end
        else
        begin
            q_reg    <= q_next;
            prod_reg <= prod_next;
            mat_reg  <= mat_next;
        end
    end

    assign mat = mat_reg;

`ifndef SYNTHESIS
    // Off-diagonal pair (0,1)/(1,0) sums to twice 2xy once products settle
    a_offdiag_pair: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(|cfg.sel) |->
        ((CHK_W'(signed'(mat_reg[1])) + CHK_W'(signed'(mat_reg[3])))
            == (CHK_W'(prod_reg[P_XY]) <<< 1)))
        else $error("matrix off-diagonal pair out of step with products");

    // Trace equals 3 - 2(xx+yy+zz) in doubled-product terms
    a_trace: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(|cfg.sel) |->
        ((CHK_W'(signed'(mat_reg[0])) + CHK_W'(signed'(mat_reg[4]))
            + CHK_W'(signed'(mat_reg[8])))
            == (CHK_W'(MAT_ONE) + CHK_W'(MAT_ONE) + CHK_W'(MAT_ONE)
                - ((CHK_W'(prod_reg[P_XX]) + CHK_W'(prod_reg[P_YY])
                    + CHK_W'(prod_reg[P_ZZ])) <<< 1))))
        else $error("matrix trace out of step with products");
`endif

endmodule

// ===== src/qrp_pipe.sv =====
module qrp_pipe (
    input  logic             clk,
    input  logic             rst_n,
    input  qrp_pkg::matrix_t mat,
    qrp_point_if.sink        point,
    qrp_rotated_if.source    rotated
);
    import qrp_pkg::*;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic adv1, adv2, adv3, adv4, adv5;

    coord_t                    c_reg    [3];
    logic signed [LO_PP_W-1:0] lo_reg   [9];
    logic signed [LO_PP_W-1:0] lo_next  [9];
    logic signed [HI_PP_W-1:0] hi_reg   [9];
    logic signed [HI_PP_W-1:0] hi_next  [9];
    logic signed [PROD_W-1:0]  full_reg [9];
    logic signed [PROD_W-1:0]  full_next[9];
    logic signed [SUM_W-1:0]   sum_reg  [3];
    logic signed [SUM_W-1:0]   sum_next [3];
    coord_t                    rot_reg  [3];
    coord_t                    rot_next [3];
    logic        [RND_W-1:0]   rnd      [3];

    // A stage advances when it is empty or its successor advances
    always_comb
    begin
        adv5 = !v5_reg || rotated.ready;
        adv4 = !v4_reg || adv5;
        adv3 = !v3_reg || adv4;
        adv2 = !v2_reg || adv3;
        adv1 = !v1_reg || adv2;
    end

    assign point.ready = adv1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                v1_reg <= point.valid;
            end
            if (adv2)
            begin
                v2_reg <= v1_reg;
            end
            if (adv3)
            begin
                v3_reg <= v2_reg;
            end
            if (adv4)
            begin
                v4_reg <= v3_reg;
            end
            if (adv5)
            begin
                v5_reg <= v4_reg;
            end
        end
    end

    // Split each entry into an unsigned low half and a signed high half
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                lo_next[3*r+c] = signed'({1'b0, mat[3*r+c][LO_W-1:0]}) * c_reg[c];
                hi_next[3*r+c] = signed'(mat[3*r+c][ENTRY_W-1:LO_W]) * c_reg[c];
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 9; i++)
        begin
            full_next[i] = (PROD_W'(hi_reg[i]) <<< LO_W) + PROD_W'(lo_reg[i]);
        end
    end

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            sum_next[r] = SUM_W'(full_reg[3*r]) + SUM_W'(full_reg[3*r+1])
                        + SUM_W'(full_reg[3*r+2]) + RND_HALF;
        end
    end

    // Drop the fraction bits, then clamp to the coordinate range
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            rnd[r] = sum_reg[r][SUM_W-1:RND_SHIFT];
            if ((&rnd[r][RND_W-1:COORD_WIDTH-1]) || !(|rnd[r][RND_W-1:COORD_WIDTH-1]))
            begin
                rot_next[r] = rnd[r][COORD_WIDTH-1:0];
            end
            else if (rnd[r][RND_W-1])
            begin
                rot_next[r] = COORD_MIN;
            end
            else
            begin
                rot_next[r] = COORD_MAX;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            c_reg[0] <= point.point_x;
            c_reg[1] <= point.point_y;
            c_reg[2] <= point.point_z;
        end
        if (adv2)
        begin
            lo_reg <= lo_next;
            hi_reg <= hi_next;
        end
        if (adv3)
        begin
            full_reg <= full_next;
        end
        if (adv4)
        begin
            sum_reg <= sum_next;
        end
        if (adv5)
        begin
            rot_reg <= rot_next;
        end
    end

    assign rotated.valid     = v5_reg;
    assign rotated.rotated_x = rot_reg[0];
    assign rotated.rotated_y = rot_reg[1];
    assign rotated.rotated_z = rot_reg[2];

`ifndef SYNTHESIS
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        point.valid && point.ready |=> v1_reg)
        else $error("accepted transaction missing from first stage");

    a_sum_holds: assert property (@(posedge clk) disable iff (!rst_n)
        v4_reg && !adv5 |=> v4_reg && $stable(sum_reg[0]))
        else $error("stalled row sum stage lost or changed its contents");

    a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg && v2_reg && v3_reg && v4_reg && v5_reg && !rotated.ready
        |-> !point.ready)
        else $error("full stalled pipeline still takes input");
`endif

endmodule

// ===== src/quaternion_rotate_point.sv =====
// Rotates each incoming 3D point by the unit quaternion held in four
// configuration registers (w, x, y, z at indexes 0..3, signed Q1.14, reset to
// the identity rotation; writes to higher indexes are ignored). The block
// builds the rotation matrix with the 1-2(yy+zz) diagonal form, multiplies the
// point by it exactly, rounds half toward plus infinity and saturates each
// coordinate to 24 bits. Throughput is one point per clock while the output is
// ready. The datapath has five register stages, the first of which captures
// the point at the edge that accepts it: input capture, 17-bit-split partial
// products, product merge, row sum with rounding, and saturation into the
// output register. Each stage stalls on its own, so bubbles fill while the
// output is held. The matrix is rebuilt through the product and matrix
// registers after a register write; software normalizes the quaternion and
// writes only while no transaction is in flight.
module quaternion_rotate_point (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [qrp_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [qrp_pkg::QREG_WIDTH-1:0]   cfg_data,
    qrp_point_if.sink                        point,
    qrp_rotated_if.source                    rotated
);
    import qrp_pkg::*;

    cfg_wr_t cfg;
    matrix_t mat;

    // Decode the write into one select per register; unknown indexes
    // select nothing.
    always_comb
    begin
        cfg.data         = cfg_data;
        cfg.sel[QPOS_W]  = cfg_wr_en && (cfg_index == ADDR_QUAT_W);
        cfg.sel[QPOS_X]  = cfg_wr_en && (cfg_index == ADDR_QUAT_X);
        cfg.sel[QPOS_Y]  = cfg_wr_en && (cfg_index == ADDR_QUAT_Y);
        cfg.sel[QPOS_Z]  = cfg_wr_en && (cfg_index == ADDR_QUAT_Z);
    end

    // Quaternion registers, doubled products and the matrix
    qrp_matrix u_matrix (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .mat   (mat)
    );

    // Point datapath: matrix times point, round and saturate
    qrp_pipe u_pipe (
        .clk     (clk),
        .rst_n   (rst_n),
        .mat     (mat),
        .point   (point),
        .rotated (rotated)
    );

endmodule
